/* sv/cpg_pkg.sv */
package cpg_pkg;

  // Default window length in bases.
  localparam int unsigned WINDOW_LEN_DEF = 200;

  // Base encodings; every other code counts as neither C nor G.
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_RATIO = 1'b0;
  localparam logic CFG_GC    = 1'b1;

  // Configuration data is as wide as the widest register.
  localparam int unsigned CFG_DW   = 6;
  localparam int unsigned RATIO_W  = 6;
  localparam int unsigned GC_W     = 4;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 6'd6;
  localparam logic [GC_W-1:0]    GC_RESET    = 4'd5;

  typedef struct packed {
    logic [1:0] base_code;
    logic       first_of_run;
    logic       last_of_run;
  } in_word_t;

  typedef struct packed {
    logic is_island;
    logic run_too_short;
  } out_word_t;

endpackage

/* sv/cpg_island_window_scan_top.sv */
// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+---------------------------------
// in      | input     | in_valid_i / in_stall_o   | in_word_i  (base, first, last)
// out     | output    | out_valid_o / out_stall_i | out_word_o (is_island, too short)
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One base word is taken per cycle unless a run end waits; a run's verdict is registered.
// The window product C*G is registered beside the counts, so each cycle holds one
// count-width multiply and one threshold multiply.
// Reset clears counts, run state, the output valid flag and the thresholds to their
// defaults; the delay line needs no clearing. While a result waits on a stalled output,
// words that do not end a run are still taken; only a word that ends a run is held off.
module cpg_island_window_scan_top #(
  parameter int unsigned WINDOW_LEN = cpg_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cpg_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cpg_pkg::out_word_t         out_word_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cpg_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned MW = 2 * CW + 6;
  localparam int unsigned GW = CW + 5;

  localparam logic [CW-1:0] WIN_FULL    = CW'(WINDOW_LEN);
  localparam logic [MW-1:0] RATIO_SCALE = MW'(WINDOW_LEN * 10);
  localparam logic [GW-1:0] GC_SCALE    = GW'(WINDOW_LEN);
  localparam logic [GW-1:0] TEN         = GW'(10);

  // Configuration registers.
  logic [cpg_pkg::RATIO_W-1:0] ratio_q;
  logic [cpg_pkg::GC_W-1:0]    gc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= cpg_pkg::RATIO_RESET;
      gc_q    <= cpg_pkg::GC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpg_pkg::CFG_RATIO: ratio_q <= cfg_data_i[cpg_pkg::RATIO_W-1:0];
        cpg_pkg::CFG_GC:    gc_q    <= cfg_data_i[cpg_pkg::GC_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: only a word that ends a run waits on a blocked output register.
  logic out_valid_q;
  logic out_blocked;
  logic in_accept;

  assign out_blocked = out_valid_q && out_stall_i;
  assign in_stall_o  = out_blocked && in_word_i.last_of_run;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Run state.
  logic [1:0]    prev_q, prev_d;
  logic [CW-1:0] cnt_c_q, cnt_c_d;
  logic [CW-1:0] cnt_g_q, cnt_g_d;
  logic [CW-1:0] cnt_cpg_q, cnt_cpg_d;
  logic [CW-1:0] seen_q, seen_d;
  logic [PW-1:0] prod_q, prod_d;
  logic          verdict_q, verdict_d;
  logic          tested_q, tested_d;

  // Delay line of the last WINDOW_LEN bases, newest at tap zero.
  logic [1:0] hist_q [WINDOW_LEN];
  logic [1:0] oldest;
  logic [1:0] second;

  assign oldest = hist_q[WINDOW_LEN-1];
  assign second = hist_q[WINDOW_LEN-2];

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hist_q[0] <= in_word_i.base_code;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // Window test and count update for one base.
  logic [1:0]    prev_c;
  logic [CW-1:0] c_c, g_c, cpg_c, seen_c;
  logic [PW-1:0] prod_c;
  logic          verdict_c, tested_c;
  logic          link;
  logic          full;
  logic [CW-1:0] cpg_sum;
  logic [MW-1:0] lhs_ratio, rhs_ratio;
  logic [GW-1:0] lhs_gc, rhs_gc;
  logic          pass;
  logic [CW-1:0] c_rm, g_rm, cpg_rm;

  always_comb begin
    // A first word starts from a cleared run.
    prev_c    = in_word_i.first_of_run ? 2'd0       : prev_q;
    c_c       = in_word_i.first_of_run ? '0         : cnt_c_q;
    g_c       = in_word_i.first_of_run ? '0         : cnt_g_q;
    cpg_c     = in_word_i.first_of_run ? '0         : cnt_cpg_q;
    seen_c    = in_word_i.first_of_run ? '0         : seen_q;
    prod_c    = in_word_i.first_of_run ? '0         : prod_q;
    verdict_c = in_word_i.first_of_run ? 1'b0       : verdict_q;
    tested_c  = in_word_i.first_of_run ? 1'b0       : tested_q;

    link = (prev_c == cpg_pkg::BASE_C) && (in_word_i.base_code == cpg_pkg::BASE_G);
    full = (seen_c >= WIN_FULL);

    // The arriving base closes a pair that starts on the last window position.
    cpg_sum   = cpg_c + CW'(link);
    lhs_ratio = MW'(cpg_sum) * RATIO_SCALE;
    rhs_ratio = MW'(ratio_q) * MW'(prod_c);
    lhs_gc    = (GW'(c_c) + GW'(g_c)) * TEN;
    rhs_gc    = GW'(gc_q) * GC_SCALE;
    pass      = (lhs_ratio > rhs_ratio) && (lhs_gc > rhs_gc);

    // Drop the oldest base once the window is full.
    c_rm   = c_c;
    g_rm   = g_c;
    cpg_rm = cpg_c;
    if (full) begin
      if (oldest == cpg_pkg::BASE_C) begin
        c_rm = c_c - CW'(1);
        if (second == cpg_pkg::BASE_G) begin
          cpg_rm = cpg_c - CW'(1);
        end
      end else if (oldest == cpg_pkg::BASE_G) begin
        g_rm = g_c - CW'(1);
      end
    end

    tested_d  = tested_c || full;
    verdict_d = verdict_c || (full && pass);
    seen_d    = full ? seen_c : seen_c + CW'(1);

    // Take the new base into the window.
    cnt_c_d   = (in_word_i.base_code == cpg_pkg::BASE_C) ? c_rm + CW'(1) : c_rm;
    cnt_g_d   = (in_word_i.base_code == cpg_pkg::BASE_G) ? g_rm + CW'(1) : g_rm;
    cnt_cpg_d = cpg_rm + CW'(link);
    prev_d    = in_word_i.base_code;
    prod_d    = PW'(cnt_c_d) * PW'(cnt_g_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 2'd0;
      cnt_c_q   <= '0;
      cnt_g_q   <= '0;
      cnt_cpg_q <= '0;
      seen_q    <= '0;
      prod_q    <= '0;
      verdict_q <= 1'b0;
      tested_q  <= 1'b0;
    end else if (in_accept) begin
      prev_q    <= prev_d;
      cnt_c_q   <= cnt_c_d;
      cnt_g_q   <= cnt_g_d;
      cnt_cpg_q <= cnt_cpg_d;
      seen_q    <= seen_d;
      prod_q    <= prod_d;
      verdict_q <= verdict_d;
      tested_q  <= tested_d;
    end
  end

  // Output register: loaded on the last word of a run.
  cpg_pkg::out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && in_word_i.last_of_run) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_word_i.last_of_run) begin
      out_word_q.is_island     <= verdict_d;
      out_word_q.run_too_short <= !tested_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* bench/tb.sv */
module tb;

  localparam int unsigned WIN = cpg_pkg::WINDOW_LEN_DEF;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned PRESSURE_PHASE = 3;
  localparam int unsigned NUM_PHASES = 6;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  cpg_pkg::in_word_t          in_word_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  cpg_pkg::out_word_t         out_word_o;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_idx_i = cpg_pkg::CFG_RATIO;
  logic [cpg_pkg::CFG_DW-1:0] cfg_data_i = '0;

  cpg_island_window_scan_top #(.WINDOW_LEN(WIN)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Stimulus and expectation stores.
  cpg_pkg::in_word_t  queued_bases[$];
  cpg_pkg::out_word_t awaited_verdicts[$];
  int unsigned words_pushed = 0;
  int unsigned words_taken = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          gaps_on = 1'b1;
  bit          hold_arm = 1'b0;

  // Predictor state: threshold copies, window delay line and running counts.
  logic [cpg_pkg::RATIO_W-1:0] ratio_thr = cpg_pkg::RATIO_RESET;
  logic [cpg_pkg::GC_W-1:0]    gc_thr = cpg_pkg::GC_RESET;
  logic [1:0]         history[WIN];
  int unsigned        slot = 0;
  logic [1:0]         prev_base = 2'd0;
  int unsigned        n_c = 0;
  int unsigned        n_g = 0;
  int unsigned        n_cpg = 0;
  int unsigned        held = 0;
  bit                 verdict = 1'b0;
  bit                 tested = 1'b0;

  // Run statistics and error count.
  int unsigned verdicts_checked = 0;
  int unsigned windowed_runs = 0;
  int unsigned islands_seen = 0;
  int unsigned bad_verdicts = 0;

  // Slide the window by one base and queue the verdict if the word ends a run.
  function automatic void scan_base(cpg_pkg::in_word_t w);
    logic [1:0]  drop;
    logic [1:0]  after_drop;
    logic        link;
    logic [63:0] ratio_lhs;
    logic [63:0] ratio_rhs;
    logic [63:0] gc_lhs;
    logic [63:0] gc_rhs;
    cpg_pkg::out_word_t v;
    if (w.first_of_run) begin
      prev_base = 2'd0;
      n_c = 0;
      n_g = 0;
      n_cpg = 0;
      held = 0;
      verdict = 1'b0;
      tested = 1'b0;
    end
    link = (prev_base == cpg_pkg::BASE_C) && (w.base_code == cpg_pkg::BASE_G);
    if (held >= WIN) begin
      drop = history[slot];
      after_drop = history[(slot + 1) % WIN];
      tested = 1'b1;
      // The incoming base closes a CpG pair that starts on the window's last base.
      ratio_lhs = 64'(n_cpg + link) * WIN * 10;
      ratio_rhs = 64'(ratio_thr) * n_c * n_g;
      gc_lhs = 64'(n_c + n_g) * 10;
      gc_rhs = 64'(gc_thr) * WIN;
      if (ratio_lhs > ratio_rhs && gc_lhs > gc_rhs) verdict = 1'b1;
      if (drop == cpg_pkg::BASE_C) begin
        n_c--;
        if (after_drop == cpg_pkg::BASE_G) n_cpg--;
      end else if (drop == cpg_pkg::BASE_G) begin
        n_g--;
      end
    end else begin
      held++;
    end
    if (w.base_code == cpg_pkg::BASE_C) n_c++;
    else if (w.base_code == cpg_pkg::BASE_G) n_g++;
    n_cpg += link;
    history[slot] = w.base_code;
    slot = (slot + 1) % WIN;
    prev_base = w.base_code;
    if (w.last_of_run) begin
      v.is_island = verdict;
      v.run_too_short = !tested;
      awaited_verdicts.push_back(v);
      if (tested) windowed_runs++;
      if (verdict) islands_seen++;
    end
  endfunction

  // Sample both handshakes, check results, then feed accepted words to the predictor.
  always @(posedge clk_i) begin
    cpg_pkg::out_word_t want;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      if (awaited_verdicts.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= 10)
          $display("ERROR: unexpected result word island=%b short=%b",
                   out_word_o.is_island, out_word_o.run_too_short);
      end else begin
        want = awaited_verdicts.pop_front();
        if (out_word_o.is_island !== want.is_island ||
            out_word_o.run_too_short !== want.run_too_short) begin
          bad_verdicts++;
          if (bad_verdicts <= 10)
            $display("ERROR: result %0d expected island=%b short=%b, got island=%b short=%b",
                     verdicts_checked, want.is_island, want.run_too_short,
                     out_word_o.is_island, out_word_o.run_too_short);
        end
        verdicts_checked++;
      end
    end
    if (in_fire) begin
      scan_base(in_word_i);
      words_taken++;
    end
  end

  // Input driver: holds a word until it is taken, then waits its drawn gap.
  always @(negedge clk_i) begin
    int unsigned feed_gap;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid_i <= 1'b0;
      end else if (queued_bases.size() != 0) begin
        in_word_i <= queued_bases.pop_front();
        in_valid_i <= 1'b1;
        feed_gap = gaps_on ? $urandom_range(0, 4) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls after each word, plus one long hold-off on request.
  always @(negedge clk_i) begin
    int unsigned hold_left;
    int unsigned stall_left;
    bit          hold_used;
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (out_fire) stall_left = gaps_on ? $urandom_range(0, 4) : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void push_word(logic [1:0] b, logic f, logic l);
    queued_bases.push_back('{base_code: b, first_of_run: f, last_of_run: l});
    words_pushed++;
  endfunction

  task automatic write_reg(input logic idx, input logic [cpg_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cpg_pkg::CFG_RATIO) ratio_thr = data[cpg_pkg::RATIO_W-1:0];
    else gc_thr = data[cpg_pkg::GC_W-1:0];
  endtask

  // Block is idle once every word is taken and every verdict has come out.
  task automatic wait_drained();
    while (words_taken != words_pushed || awaited_verdicts.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    int unsigned      ph;
    int unsigned      len;
    int unsigned      mode;
    int unsigned      phase_words;
    int unsigned      phase_runs;
    logic [cpg_pkg::CFG_DW-1:0] r_data;
    logic [cpg_pkg::CFG_DW-1:0] g_data;
    logic [1:0]       b;
    logic             f;
    logic             l;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset thresholds.
    // A run that never saw a first flag after reset, on an "other" code.
    push_word(2'd3, 1'b0, 1'b1);
    // First and last on the same word.
    push_word(cpg_pkg::BASE_C, 1'b1, 1'b1);
    // Every base code in one short run.
    push_word(2'd0, 1'b1, 1'b0);
    push_word(cpg_pkg::BASE_C, 1'b0, 1'b0);
    push_word(cpg_pkg::BASE_G, 1'b0, 1'b0);
    push_word(2'd3, 1'b0, 1'b0);
    push_word(cpg_pkg::BASE_G, 1'b0, 1'b1);
    // A run that carries on without a first flag.
    push_word(cpg_pkg::BASE_C, 1'b0, 1'b0);
    push_word(cpg_pkg::BASE_G, 1'b0, 1'b1);
    // A first flag in the middle of an open run clears it.
    push_word(cpg_pkg::BASE_G, 1'b1, 1'b0);
    push_word(cpg_pkg::BASE_C, 1'b0, 1'b0);
    push_word(cpg_pkg::BASE_C, 1'b1, 1'b1);
    // A dangling word, then a fresh single-word run.
    push_word(2'd0, 1'b0, 1'b0);
    push_word(2'd3, 1'b1, 1'b1);
    wait_drained();

    // Random phases, each under its own pair of thresholds.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          r_data = 6'd0;
          g_data = 6'd0;
          gaps_on = 1'b1;
        end
        1: begin
          r_data = 6'd40;
          g_data = 6'd10;
          gaps_on = 1'b1;
        end
        2: begin
          r_data = 6'd63;
          g_data = 6'd15;
          gaps_on = 1'b0;
        end
        3: begin
          // Upper data bits of the GC write must be dropped.
          r_data = 6'd6;
          g_data = 6'd37;
          gaps_on = 1'b0;
        end
        4: begin
          r_data = 6'($urandom_range(0, 40));
          g_data = 6'($urandom_range(0, 10));
          gaps_on = 1'b1;
        end
        default: begin
          r_data = 6'd6;
          g_data = 6'd5;
          gaps_on = 1'b1;
        end
      endcase
      write_reg(cpg_pkg::CFG_RATIO, r_data);
      write_reg(cpg_pkg::CFG_GC, g_data);
      if (ph == PRESSURE_PHASE) hold_arm = 1'b1;

      phase_words = 0;
      phase_runs = 0;
      l = 1'b1;
      while (phase_words < 180 || phase_runs < 8) begin
        if (ph == PRESSURE_PHASE) len = $urandom_range(1, 4);
        else if ($urandom_range(0, 3) == 0) len = WIN - 5 + $urandom_range(0, 45);
        else len = $urandom_range(1, 20);
        mode = $urandom_range(0, 4);
        f = ($urandom_range(0, 9) != 0);
        l = ($urandom_range(0, 9) != 0);
        b = 2'd0;
        for (int unsigned i = 0; i < len; i++) begin
          case (mode)
            // Alternating C and G with some noise: CpG-rich.
            1: b = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) :
                   ((i % 2 == 0) ? cpg_pkg::BASE_C : cpg_pkg::BASE_G);
            // Blocks of G then C: GC-rich with few CpG pairs.
            2: b = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) :
                   ((i % 20 < 10) ? cpg_pkg::BASE_G : cpg_pkg::BASE_C);
            // A full window of C with a G right after it: window without any G.
            3: b = (i < WIN) ? cpg_pkg::BASE_C :
                   ((i == WIN) ? cpg_pkg::BASE_G : 2'($urandom_range(0, 3)));
            // Mostly C and G in random order: near the thresholds.
            4: b = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
                   2'($urandom_range(1, 2));
            default: b = 2'($urandom_range(0, 3));
          endcase
          push_word(b, f && (i == 0), l && (i == len - 1));
        end
        phase_words += len;
        if (l) phase_runs++;
      end
      if (!l) push_word(2'($urandom_range(0, 3)), 1'b0, 1'b1);
      wait_drained();
    end

    $display("Checked %0d verdicts over %0d bases: %0d runs held a full window, %0d islands.",
             verdicts_checked, words_taken, windowed_runs, islands_seen);
    $display("Thresholds went through %0d settings including both extremes.", NUM_PHASES + 1);
    if (bad_verdicts == 0 && awaited_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #4000000;
    $display("Timeout with %0d verdicts outstanding", awaited_verdicts.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
sv/cpg_pkg.sv
sv/cpg_island_window_scan_top.sv
bench/tb.sv
